### design/lude_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lude_pkg
// Types and constants shared by the LU decomposition engine.
// ----------------------------------------------------------------------------
package lude_pkg;

   localparam int IDX_W  = 3;
   localparam int ADDR_W = 6;
   localparam int SIZE_W = 4;
   localparam int DATA_W = 32;
   localparam int ACC_W  = 64;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_ROW,
      ST_TERM,
      ST_MRD,
      ST_MMUL,
      ST_MACC,
      ST_FIN,
      ST_PIV_RD,
      ST_PIV_CHK,
      ST_DIV,
      ST_LWR,
      ST_SING,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } lude_state_type;

   typedef enum logic [1:0] {
      LSEL_ZERO,
      LSEL_ONE,
      LSEL_DATA
   } lude_lsel_type;

   typedef struct packed {
      logic                a_wr;
      logic                u_wr;
      logic                l_wr;
      logic [ADDR_W-1:0]   w_addr;
      logic [ADDR_W-1:0]   a_addr;
      logic [ADDR_W-1:0]   l_addr;
      logic [ADDR_W-1:0]   u_addr;
      logic                acc_clr;
      logic                mul_en;
      logic                acc_en;
      logic                pivot_ld;
      logic                div_start;
      logic                div_step;
      logic                out_ld;
      logic [IDX_W-1:0]    out_row;
      logic [IDX_W-1:0]    out_col;
      lude_lsel_type       out_lsel;
      logic                out_upass;
      logic                out_sing;
      logic                out_last;
   } lude_cmd_type;

   typedef struct packed {
      logic pivot_zero;
      logic div_done;
      logic out_free;
   } lude_status_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(64'sh0000_0000_7fff_ffff);
      lo = -hi - ACC_W'(64'sd1);
      if (v > hi) begin
         sat32 = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v < lo) begin
         sat32 = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat32 = v[DATA_W-1:0];
      end
   endfunction

endpackage

### design/lude_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lude_ctrl
// Sequencer: loads the matrix, walks the Doolittle loops and drives results.
// ----------------------------------------------------------------------------
module lude_ctrl import lude_pkg::*; #(
   parameter int MAX_ORDER = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                csr_valid,
   input  logic [SIZE_W-1:0]   csr_matrix_size,
   input  lude_status_type     status,
   output lude_cmd_type        cmd
);

   lude_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   i_ff, i_in, k_ff, k_in, j_ff, j_in, r_ff, r_in, c_ff, c_in;
   logic               mode_ff, mode_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [SIZE_W-1:0]  order;
   logic [IDX_W-1:0]   nm1;

   function automatic logic [ADDR_W-1:0] addr(input logic [IDX_W-1:0] r,
                                              input logic [IDX_W-1:0] c);
      addr = ADDR_W'(r) * ADDR_W'(MAX_ORDER) + ADDR_W'(c);
   endfunction

   always_comb begin
      if (size_ff == '0) begin
         order = SIZE_W'(1);
      end else if (size_ff > SIZE_W'(MAX_ORDER)) begin
         order = SIZE_W'(MAX_ORDER);
      end else begin
         order = size_ff;
      end
      nm1 = IDX_W'(order - SIZE_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         i_ff     <= '0;
         k_ff     <= '0;
         j_ff     <= '0;
         r_ff     <= '0;
         c_ff     <= '0;
         mode_ff  <= 1'b0;
         size_ff  <= SIZE_W'(8);
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         k_ff     <= k_in;
         j_ff     <= j_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         mode_ff  <= mode_in;
         size_ff  <= size_in;
      end
   end

   assign req_ready = (state_ff == ST_LOAD);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      mode_in  = mode_ff;
      size_in  = size_ff;

      cmd           = '0;
      cmd.out_lsel  = LSEL_ZERO;
      cmd.w_addr    = addr(r_ff, c_ff);
      cmd.a_addr    = mode_ff ? addr(k_ff, i_ff) : addr(i_ff, k_ff);
      cmd.l_addr    = mode_ff ? addr(k_ff, j_ff) : addr(i_ff, j_ff);
      cmd.u_addr    = mode_ff ? addr(j_ff, i_ff) : addr(j_ff, k_ff);
      cmd.out_row   = r_ff;
      cmd.out_col   = c_ff;

      case (state_ff)
         ST_LOAD: begin
            cmd.a_wr = req_valid;
            if (req_valid) begin
               if (c_ff == nm1) begin
                  c_in = '0;
                  if (r_ff == nm1) begin
                     r_in     = '0;
                     i_in     = '0;
                     state_in = ST_ROW;
                  end else begin
                     r_in = r_ff + IDX_W'(1);
                  end
               end else begin
                  c_in = c_ff + IDX_W'(1);
               end
            end
         end
         ST_ROW: begin
            k_in     = i_ff;
            mode_in  = 1'b0;
            state_in = ST_TERM;
         end
         ST_TERM: begin
            cmd.acc_clr = 1'b1;
            j_in        = '0;
            state_in    = (i_ff == '0) ? ST_FIN : ST_MRD;
         end
         ST_MRD: begin
            state_in = ST_MMUL;
         end
         ST_MMUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_MACC;
         end
         ST_MACC: begin
            cmd.acc_en = 1'b1;
            if (j_ff == i_ff - IDX_W'(1)) begin
               state_in = ST_FIN;
            end else begin
               j_in     = j_ff + IDX_W'(1);
               state_in = ST_MRD;
            end
         end
         ST_FIN: begin
            if (!mode_ff) begin
               cmd.u_wr   = 1'b1;
               cmd.w_addr = addr(i_ff, k_ff);
               if (k_ff == nm1) begin
                  state_in = ST_PIV_RD;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = ST_TERM;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_PIV_RD: begin
            cmd.u_addr = addr(i_ff, i_ff);
            state_in   = ST_PIV_CHK;
         end
         ST_PIV_CHK: begin
            cmd.u_addr   = addr(i_ff, i_ff);
            cmd.pivot_ld = 1'b1;
            if (i_ff == nm1) begin
               r_in     = '0;
               c_in     = '0;
               state_in = ST_EMIT_RD;
            end else if (status.pivot_zero) begin
               state_in = ST_SING;
            end else begin
               mode_in  = 1'b1;
               k_in     = i_ff + IDX_W'(1);
               state_in = ST_TERM;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_LWR;
            end
         end
         ST_LWR: begin
            cmd.l_wr   = 1'b1;
            cmd.w_addr = addr(k_ff, i_ff);
            if (k_ff == nm1) begin
               i_in     = i_ff + IDX_W'(1);
               state_in = ST_ROW;
            end else begin
               k_in     = k_ff + IDX_W'(1);
               state_in = ST_TERM;
            end
         end
         ST_SING: begin
            cmd.out_row  = i_ff;
            cmd.out_col  = i_ff;
            cmd.out_sing = 1'b1;
            cmd.out_last = 1'b1;
            if (status.out_free) begin
               cmd.out_ld = 1'b1;
               r_in       = '0;
               c_in       = '0;
               state_in   = ST_LOAD;
            end
         end
         ST_EMIT_RD: begin
            cmd.l_addr = addr(r_ff, c_ff);
            cmd.u_addr = addr(r_ff, c_ff);
            state_in   = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            cmd.l_addr    = addr(r_ff, c_ff);
            cmd.u_addr    = addr(r_ff, c_ff);
            cmd.out_lsel  = (r_ff > c_ff) ? LSEL_DATA :
                            ((r_ff == c_ff) ? LSEL_ONE : LSEL_ZERO);
            cmd.out_upass = (c_ff >= r_ff);
            cmd.out_last  = (r_ff == nm1) && (c_ff == nm1);
            if (status.out_free) begin
               cmd.out_ld = 1'b1;
               if (c_ff == nm1) begin
                  c_in = '0;
                  if (r_ff == nm1) begin
                     r_in     = '0;
                     state_in = ST_LOAD;
                  end else begin
                     r_in     = r_ff + IDX_W'(1);
                     state_in = ST_EMIT_RD;
                  end
               end else begin
                  c_in     = c_ff + IDX_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (csr_valid) begin
         size_in = csr_matrix_size;
         r_in    = '0;
         c_in    = '0;
      end
   end

endmodule

### design/lude_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lude_datapath
// Matrix stores, multiply-accumulate, bit-serial divider and result register.
// ----------------------------------------------------------------------------
module lude_datapath import lude_pkg::*; #(
   parameter int MAX_ORDER = 8,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lude_cmd_type                cmd,
   output lude_status_type             status,
   input  logic signed [DATA_W-1:0]    req_element_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [IDX_W-1:0]            rsp_row_index,
   output logic [IDX_W-1:0]            rsp_col_index,
   output logic signed [DATA_W-1:0]    rsp_lower_value,
   output logic signed [DATA_W-1:0]    rsp_upper_value,
   output logic                        rsp_singular,
   output logic                        rsp_last_result
);

   localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
   localparam int AW        = $clog2(DEPTH);
   localparam int DIV_STEPS = ACC_W + FRAC_BITS;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   logic signed [DATA_W-1:0] a_mem [DEPTH];
   logic signed [DATA_W-1:0] l_mem [DEPTH];
   logic signed [DATA_W-1:0] u_mem [DEPTH];

   logic signed [DATA_W-1:0]   a_rd_ff, l_rd_ff, u_rd_ff, pivot_ff;
   logic signed [2*DATA_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [ACC_W-1:0]    rounded, diff;
   logic signed [DATA_W-1:0]   u_val, l_val, one_val;

   logic [ACC_W-1:0]   dvd_ff, dvd_in;
   logic [DATA_W-1:0]  rem_ff, rem_in, ud_ff, ud_in;
   logic [DATA_W:0]    rem_sh;
   logic [DATA_W:0]    q_ff, q_in;
   logic               ovf_ff, ovf_in, neg_ff, neg_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic                     out_valid_ff;
   logic [IDX_W-1:0]         out_row_ff, out_col_ff;
   logic signed [DATA_W-1:0] out_lower_ff, out_upper_ff;
   logic                     out_sing_ff, out_last_ff;

   always_ff @(posedge clock) begin
      if (cmd.a_wr) begin
         a_mem[cmd.w_addr[AW-1:0]] <= req_element_value;
      end
      if (cmd.u_wr) begin
         u_mem[cmd.w_addr[AW-1:0]] <= u_val;
      end
      if (cmd.l_wr) begin
         l_mem[cmd.w_addr[AW-1:0]] <= l_val;
      end
      a_rd_ff <= a_mem[cmd.a_addr[AW-1:0]];
      l_rd_ff <= l_mem[cmd.l_addr[AW-1:0]];
      u_rd_ff <= u_mem[cmd.u_addr[AW-1:0]];
   end

   assign rounded = (prod_ff + ACC_W'(64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   assign diff    = ACC_W'(a_rd_ff) - acc_ff;
   assign u_val   = sat32(diff);
   assign one_val = DATA_W'(1) << FRAC_BITS;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (cmd.acc_en) begin
         acc_in = acc_ff + rounded;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= l_rd_ff * u_rd_ff;
      end
      if (cmd.pivot_ld) begin
         pivot_ff <= u_rd_ff;
      end
      acc_ff <= acc_in;
   end

   assign rem_sh = {rem_ff, dvd_ff[ACC_W-1]};

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      ud_in  = ud_ff;
      q_in   = q_ff;
      ovf_in = ovf_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      if (cmd.div_start) begin
         neg_in = diff[ACC_W-1] ^ pivot_ff[DATA_W-1];
         dvd_in = diff[ACC_W-1] ? ACC_W'(-diff) : diff;
         ud_in  = pivot_ff[DATA_W-1] ? DATA_W'(-pivot_ff) : pivot_ff;
         rem_in = '0;
         q_in   = '0;
         ovf_in = 1'b0;
         cnt_in = CNT_W'(DIV_STEPS);
      end else if (cmd.div_step && cnt_ff != '0) begin
         dvd_in = {dvd_ff[ACC_W-2:0], 1'b0};
         ovf_in = ovf_ff | q_ff[DATA_W];
         if (rem_sh >= {1'b0, ud_ff}) begin
            rem_in = DATA_W'(rem_sh - {1'b0, ud_ff});
            q_in   = {q_ff[DATA_W-1:0], 1'b1};
         end else begin
            rem_in = rem_sh[DATA_W-1:0];
            q_in   = {q_ff[DATA_W-1:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      ud_ff  <= ud_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      if (!neg_ff) begin
         if (ovf_ff || q_ff[DATA_W] || q_ff[DATA_W-1]) begin
            l_val = {1'b0, {(DATA_W-1){1'b1}}};
         end else begin
            l_val = q_ff[DATA_W-1:0];
         end
      end else begin
         if (ovf_ff || q_ff[DATA_W] || (q_ff[DATA_W-1] && q_ff[DATA_W-2:0] != '0)) begin
            l_val = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            l_val = DATA_W'(-q_ff[DATA_W-1:0]);
         end
      end
   end

   assign status.pivot_zero = (u_rd_ff == '0);
   assign status.div_done   = (cnt_ff == '0);
   assign status.out_free   = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_ld) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.out_ld) begin
         out_row_ff  <= cmd.out_row;
         out_col_ff  <= cmd.out_col;
         out_sing_ff <= cmd.out_sing;
         out_last_ff <= cmd.out_last;
         out_upper_ff <= cmd.out_upass ? u_rd_ff : '0;
         case (cmd.out_lsel)
            LSEL_DATA: out_lower_ff <= l_rd_ff;
            LSEL_ONE:  out_lower_ff <= one_val;
            LSEL_ZERO: out_lower_ff <= '0;
            default:   out_lower_ff <= '0;
         endcase
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_row_index   = out_row_ff;
   assign rsp_col_index   = out_col_ff;
   assign rsp_lower_value = out_lower_ff;
   assign rsp_upper_value = out_upper_ff;
   assign rsp_singular    = out_sing_ff;
   assign rsp_last_result = out_last_ff;

endmodule

### design/lu_decomposition_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_decomposition_engine_top
// Streaming Doolittle LU factoriser for an n-by-n Q16.16 matrix.
//
//   channel  direction  beat
//   req      in         one matrix element, row-major
//   rsp      out        one (row, col) pair of L and U entries, or a singular flag
//   csr      in         matrix order n
//
// Loading accepts one element per cycle. Row i computes its (n-i) U terms, then
// checks the pivot, then its (n-i-1) L terms, each L term also passing through
// the single shared bit-serial divider and the write-back. Results leave one
// at a time, each read from the stores before it is registered; rsp stalls
// hold the sequencer. Reset is synchronous and clears control state only.
// ----------------------------------------------------------------------------
module lu_decomposition_engine_top import lude_pkg::*; #(
   parameter int MAX_ORDER = 8,
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [DATA_W-1:0]  req_element_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [IDX_W-1:0]          rsp_row_index,
   output logic [IDX_W-1:0]          rsp_col_index,
   output logic signed [DATA_W-1:0]  rsp_lower_value,
   output logic signed [DATA_W-1:0]  rsp_upper_value,
   output logic                      rsp_singular,
   output logic                      rsp_last_result,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [SIZE_W-1:0]         csr_matrix_size
);

   lude_cmd_type    cmd;
   lude_status_type status;

   assign csr_ready = 1'b1;

   lude_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .csr_valid       (csr_valid),
      .csr_matrix_size (csr_matrix_size),
      .status          (status),
      .cmd             (cmd)
   );

   lude_datapath #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_row_index     (rsp_row_index),
      .rsp_col_index     (rsp_col_index),
      .rsp_lower_value   (rsp_lower_value),
      .rsp_upper_value   (rsp_upper_value),
      .rsp_singular      (rsp_singular),
      .rsp_last_result   (rsp_last_result)
   );

endmodule

### design/lude_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lude_checker
// Port-level checks on the result stream of the LU engine.
// ----------------------------------------------------------------------------
module lude_checker import lude_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [IDX_W-1:0]          rsp_row_index,
   input logic [IDX_W-1:0]          rsp_col_index,
   input logic signed [DATA_W-1:0]  rsp_lower_value,
   input logic signed [DATA_W-1:0]  rsp_upper_value,
   input logic                      rsp_singular,
   input logic                      rsp_last_result
);

   localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lower_value)
                                  && $stable(rsp_upper_value))
      else $error("rsp beat changed while stalled");

   a_sing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_last_result && rsp_lower_value == '0
         && rsp_upper_value == '0 && rsp_row_index == rsp_col_index)
      else $error("malformed singular beat");

   a_diag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_singular && rsp_row_index == rsp_col_index
         |-> rsp_lower_value == ONE)
      else $error("lower diagonal not unity");

   a_tri: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_singular && rsp_row_index != rsp_col_index
         |-> (rsp_row_index < rsp_col_index) ? rsp_lower_value == '0
                                             : rsp_upper_value == '0)
      else $error("factor not triangular");

endmodule

bind lu_decomposition_engine_top lude_checker #(.FRAC_BITS(FRAC_BITS)) u_lude_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_row_index   (rsp_row_index),
   .rsp_col_index   (rsp_col_index),
   .rsp_lower_value (rsp_lower_value),
   .rsp_upper_value (rsp_upper_value),
   .rsp_singular    (rsp_singular),
   .rsp_last_result (rsp_last_result)
);

### tb/lu_decomposition_engine_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_decomposition_engine_top_test
// Self-checking bench for the streaming Doolittle LU factoriser.
//
// Matrices of every order are streamed in row-major, with the order register
// rewritten between matrices and also part way through a load. A local
// fixed-point factoriser predicts every (row, col) beat or the singular beat,
// and a monitor compares each rsp beat field by field. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module lu_decomposition_engine_top_test;
   import lude_pkg::*;

   localparam int FRAC       = 16;
   localparam int ORD_MAX    = 8;
   localparam int SETTLE     = 40;
   localparam int LIMIT      = 1_000_000;
   localparam int ITEM_GOAL  = 180;

   typedef enum logic [1:0] {K_ELEM, K_CFG, K_DRAIN} job_kind_type;

   typedef struct {
      job_kind_type        kind;
      logic [DATA_W-1:0]   value;
   } job_type;

   typedef struct {
      logic [IDX_W-1:0]          row;
      logic [IDX_W-1:0]          col;
      logic signed [DATA_W-1:0]  lower;
      logic signed [DATA_W-1:0]  upper;
      logic                      sing;
      logic                      last;
   } lu_entry_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [DATA_W-1:0]  req_element_value;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [IDX_W-1:0]          rsp_row_index;
   logic [IDX_W-1:0]          rsp_col_index;
   logic signed [DATA_W-1:0]  rsp_lower_value;
   logic signed [DATA_W-1:0]  rsp_upper_value;
   logic                      rsp_singular;
   logic                      rsp_last_result;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [SIZE_W-1:0]         csr_matrix_size;

   lu_decomposition_engine_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_row_index     (rsp_row_index),
      .rsp_col_index     (rsp_col_index),
      .rsp_lower_value   (rsp_lower_value),
      .rsp_upper_value   (rsp_upper_value),
      .rsp_singular      (rsp_singular),
      .rsp_last_result   (rsp_last_result),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_matrix_size   (csr_matrix_size)
   );

   job_type                   pending[$];
   lu_entry_type              lu_expected[$];
   logic [SIZE_W-1:0]         size_code;
   int unsigned               elems_loaded;
   logic signed [DATA_W-1:0]  a_mat [0:63];
   logic signed [DATA_W-1:0]  l_mat [0:63];
   logic signed [DATA_W-1:0]  u_mat [0:63];
   int unsigned               errors;
   int unsigned               beats_checked;
   int unsigned               matrices_done;
   int unsigned               singular_seen;
   int unsigned               cycles;
   int unsigned               quiet;
   int unsigned               req_gap;
   int unsigned               rsp_stall;
   int unsigned               elem_total;
   logic                      calm;
   logic                      nxt_req;
   logic                      nxt_csr;

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm)
         return 0;
      if (r < 65)
         return 0;
      if (r < 94)
         return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   function automatic logic signed [DATA_W-1:0] clip32(input logic signed [63:0] v);
      if (v > 64'sh7fff_ffff)
         return 32'sh7fff_ffff;
      if (v < -64'sh8000_0000)
         return 32'sh8000_0000;
      return v[DATA_W-1:0];
   endfunction

   function automatic logic signed [63:0] fx_product(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return (p + 64'sd32768) >>> FRAC;
   endfunction

   function automatic logic signed [DATA_W-1:0] fx_quotient(input logic signed [63:0] num,
                                                            input logic signed [DATA_W-1:0] den);
      logic               neg;
      logic [127:0]       un;
      logic [127:0]       ud;
      logic [127:0]       q;
      logic signed [63:0] d64;
      logic signed [63:0] res;
      d64 = den;
      neg = (num < 0) != (d64 < 0);
      un  = 128'(num < 0 ? -num : num);
      ud  = 128'(d64 < 0 ? -d64 : d64);
      q   = (un << FRAC) / ud;
      if (q > 128'h1_0000_0001)
         q = 128'h1_0000_0001;
      res = neg ? -$signed(q[63:0]) : $signed(q[63:0]);
      return clip32(res);
   endfunction

   function automatic int unsigned order_of(input logic [SIZE_W-1:0] code);
      if (code == 0)
         return 1;
      if (code > ORD_MAX)
         return ORD_MAX;
      return 32'(code);
   endfunction

   task automatic push_entry(input int r, input int c, input logic signed [DATA_W-1:0] lo,
                             input logic signed [DATA_W-1:0] up, input logic sg,
                             input logic lst);
      lu_entry_type e;
      e.row   = r[IDX_W-1:0];
      e.col   = c[IDX_W-1:0];
      e.lower = lo;
      e.upper = up;
      e.sing  = sg;
      e.last  = lst;
      lu_expected.push_back(e);
   endtask

   task automatic factorise();
      int unsigned        n;
      logic signed [63:0] acc;
      logic signed [DATA_W-1:0] lo;
      logic signed [DATA_W-1:0] up;
      n = order_of(size_code);
      matrices_done++;
      for (int i = 0; i < n; i++) begin
         for (int k = i; k < n; k++) begin
            acc = 0;
            for (int j = 0; j < i; j++)
               acc += fx_product(l_mat[i*n+j], u_mat[j*n+k]);
            u_mat[i*n+k] = clip32(64'(a_mat[i*n+k]) - acc);
         end
         l_mat[i*n+i] = 32'sd1 <<< FRAC;
         if (i + 1 < n && u_mat[i*n+i] == 0) begin
            singular_seen++;
            push_entry(i, i, 0, 0, 1'b1, 1'b1);
            return;
         end
         for (int k = i + 1; k < n; k++) begin
            acc = 0;
            for (int j = 0; j < i; j++)
               acc += fx_product(l_mat[k*n+j], u_mat[j*n+i]);
            l_mat[k*n+i] = fx_quotient(64'(a_mat[k*n+i]) - acc, u_mat[i*n+i]);
         end
      end
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            lo = i > j ? l_mat[i*n+j] : (i == j ? 32'sd1 <<< FRAC : 32'sd0);
            up = j >= i ? u_mat[i*n+j] : 32'sd0;
            push_entry(i, j, lo, up, 1'b0, (i*n + j + 1) == n*n);
         end
      end
   endtask

   task automatic take_element(input logic signed [DATA_W-1:0] v);
      int unsigned total;
      total = order_of(size_code) * order_of(size_code);
      if (elems_loaded >= total)
         elems_loaded = 0;
      a_mat[elems_loaded % 64] = v;
      elems_loaded++;
      if (elems_loaded >= total) begin
         elems_loaded = 0;
         factorise();
      end
   endtask

   task automatic report(input string what, input logic signed [63:0] got,
                         input logic signed [63:0] want);
      errors++;
      $display("mismatch at beat %0d: %s got %0d expected %0d", beats_checked, what, got,
               want);
   endtask

   // stimulus queue helpers
   task automatic add_job(input job_kind_type k, input logic [DATA_W-1:0] v);
      job_type jb;
      jb.kind  = k;
      jb.value = v;
      pending.push_back(jb);
      if (k == K_ELEM)
         elem_total++;
   endtask

   function automatic logic [DATA_W-1:0] rand_element();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return 0;
      if (r < 25)
         return $urandom;
      if (r < 50)
         return 32'($signed($urandom_range(0, 8)) - 4) <<< FRAC;
      return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
   endfunction

   task automatic add_matrix(input int unsigned count);
      for (int i = 0; i < count; i++)
         add_job(K_ELEM, rand_element());
   endtask

   // clock and reset
   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_element_value = '0;
      csr_valid         = 1'b0;
      csr_matrix_size   = '0;
      rsp_ready         = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      int unsigned sz;
      int unsigned n;
      size_code     = 4'd8;
      elems_loaded  = 0;
      errors        = 0;
      beats_checked = 0;
      matrices_done = 0;
      singular_seen = 0;
      cycles        = 0;
      quiet         = 0;
      req_gap       = 0;
      rsp_stall     = 0;
      elem_total    = 0;
      calm          = 1'b0;

      // order 1: extremes, zero last pivot is not singular
      add_job(K_CFG, 1);
      add_job(K_ELEM, 32'h8000_0000);
      add_job(K_ELEM, 32'h0000_0000);
      add_job(K_CFG, 0);
      add_job(K_ELEM, 32'h7fff_ffff);
      // order 2: zero leading pivot
      add_job(K_CFG, 2);
      add_job(K_ELEM, 0);
      add_job(K_ELEM, 32'h0001_0000);
      add_job(K_ELEM, 32'h0002_0000);
      add_job(K_ELEM, 32'h0003_0000);
      // order 2: saturating quotient and difference
      add_job(K_ELEM, 32'h0000_0001);
      add_job(K_ELEM, 32'h7fff_ffff);
      add_job(K_ELEM, 32'h8000_0000);
      add_job(K_ELEM, 32'h7fff_ffff);
      // order 3: rank one, singular on the second row; restarted mid-load
      add_job(K_CFG, 3);
      add_job(K_ELEM, 32'h1234_5678);
      add_job(K_ELEM, 32'hfedc_ba98);
      add_job(K_CFG, 3);
      for (int i = 0; i < 9; i++)
         add_job(K_ELEM, 32'h0001_0000);
      add_job(K_DRAIN, 0);

      // order code above the maximum acts as full order
      add_job(K_CFG, 15);
      add_matrix(64);
      while (elem_total < ITEM_GOAL) begin
         sz = $urandom_range(0, 99) < 85 ? $urandom_range(2, 4) : $urandom_range(0, 8);
         n  = order_of(SIZE_W'(sz));
         add_job(K_CFG, sz);
         if ($urandom_range(0, 7) == 0)
            add_matrix($urandom_range(1, n*n));
         if ($urandom_range(0, 7) == 0)
            add_job(K_CFG, sz);
         add_matrix(n*n);
         if ($urandom_range(0, 2) == 0)
            add_matrix(n*n);
         if ($urandom_range(0, 9) == 0)
            add_job(K_DRAIN, 0);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait (pending.size() == 0 && !req_valid && !csr_valid && lu_expected.size() == 0);
      repeat (200) @(posedge clock);
      $display("factored %0d matrices (%0d singular), %0d beats checked, orders 1 to %0d",
               matrices_done, singular_seen, beats_checked, ORD_MAX);
      $display("order register written with 0, 1, in-range and over-range codes");
      if (errors == 0 && lu_expected.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         nxt_req = req_valid;
         nxt_csr = csr_valid;
         if (req_valid && req_ready) begin
            take_element(req_element_value);
            nxt_req = 1'b0;
            req_gap = gap_len();
         end
         if (csr_valid && csr_ready) begin
            size_code    = csr_matrix_size;
            elems_loaded = 0;
            nxt_csr      = 1'b0;
            req_gap      = gap_len();
         end
         quiet = lu_expected.size() == 0 ? quiet + 1 : 0;
         if (!nxt_req && !nxt_csr && pending.size() > 0) begin
            if (req_gap > 0) begin
               req_gap--;
            end else begin
               case (pending[0].kind)
                  K_ELEM: begin
                     nxt_req = 1'b1;
                     req_element_value <= pending[0].value;
                     void'(pending.pop_front());
                  end
                  K_CFG: begin
                     if (quiet >= SETTLE) begin
                        nxt_csr = 1'b1;
                        csr_matrix_size <= pending[0].value[SIZE_W-1:0];
                        void'(pending.pop_front());
                     end
                  end
                  default: begin
                     if (quiet >= SETTLE)
                        void'(pending.pop_front());
                  end
               endcase
            end
         end
         req_valid <= nxt_req;
         csr_valid <= nxt_csr;
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall = gap_len();
      end
   end

   // monitor
   always @(posedge clock) begin
      lu_entry_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (lu_expected.size() == 0) begin
            report("unexpected beat, row", rsp_row_index, -1);
         end else begin
            e = lu_expected.pop_front();
            if (rsp_row_index !== e.row)
               report("row_index", rsp_row_index, e.row);
            if (rsp_col_index !== e.col)
               report("col_index", rsp_col_index, e.col);
            if (rsp_lower_value !== e.lower)
               report("lower_value", rsp_lower_value, e.lower);
            if (rsp_upper_value !== e.upper)
               report("upper_value", rsp_upper_value, e.upper);
            if (rsp_singular !== e.sing)
               report("singular", rsp_singular, e.sing);
            if (rsp_last_result !== e.last)
               report("last_result", rsp_last_result, e.last);
         end
         beats_checked++;
      end
   end

   // watchdog; toggle calm stretches
   always @(posedge clock) begin
      cycles++;
      if (cycles % 500 == 0)
         calm <= $urandom_range(0, 3) == 0;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycles,
                  lu_expected.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule
